### rtl/rvpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvpc_pkg: shared types and constants of the rotary valve position controller
// operation, drive and status codes, register indexes, configuration struct
// ----------------------------------------------------------------------------
package rvpc_pkg;

  localparam int NUM_DETENTS     = 5;
  localparam int CENTER_WIDTH    = 15;
  localparam int TOL_WIDTH       = 10;
  localparam int TIMEOUT_WIDTH   = 16;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH  = 16;

  typedef enum logic [1:0] {
    OP_TICK      = 2'd0,
    OP_TARGET    = 2'd1,
    OP_CALIBRATE = 2'd2,
    OP_UNUSED    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DRIVE_STOP = 2'd0,
    DRIVE_CW   = 2'd1,
    DRIVE_CCW  = 2'd2
  } drive_t;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED = 2'd0,
    STATUS_REJECTED = 2'd1,
    STATUS_NONE     = 2'd2
  } status_t;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER1   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER2   = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER3   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER4   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CENTER5   = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOLERANCE = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIMEOUT   = 3'd6;

  // detent numbers
  localparam logic [2:0] DETENT_NONE  = 3'd0;
  localparam logic [2:0] DETENT_FIRST = 3'd1;
  localparam logic [2:0] DETENT_2     = 3'd2;
  localparam logic [2:0] DETENT_3     = 3'd3;
  localparam logic [2:0] DETENT_4     = 3'd4;
  localparam logic [2:0] DETENT_LAST  = 3'd5;

  typedef struct packed {
    logic [NUM_DETENTS-1:0][CENTER_WIDTH-1:0] center;
    logic [TOL_WIDTH-1:0]                     tolerance;
    logic [TIMEOUT_WIDTH-1:0]                 timeout;
  } cfg_t;

  localparam logic [CENTER_WIDTH-1:0] CENTER1_RESET = 15'd0;
  localparam logic [CENTER_WIDTH-1:0] CENTER2_RESET = 15'd240;
  localparam logic [CENTER_WIDTH-1:0] CENTER3_RESET = 15'd450;
  localparam logic [CENTER_WIDTH-1:0] CENTER4_RESET = 15'd670;
  localparam logic [CENTER_WIDTH-1:0] CENTER5_RESET = 15'd950;
  localparam logic [TOL_WIDTH-1:0]     TOLERANCE_RESET = 10'd10;
  localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET   = 16'd100;

  // what the detent finder reports for one count
  typedef struct packed {
    logic [2:0] nearest;
    logic       in_tolerance;
    logic       err_positive;
  } detent_info_t;

endpackage

### rtl/rvpc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvpc channels: request, result and configuration write interfaces
// valid/ready handshake, payload carried alongside
// ----------------------------------------------------------------------------
interface rvpc_cmd_if #(
  parameter int COUNT_WIDTH = 16,
  parameter int TIME_WIDTH  = 32
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    op;
  logic [2:0]                    target_request;
  logic signed [COUNT_WIDTH-1:0] pulse_count;
  logic [TIME_WIDTH-1:0]         now_time;

  modport source (output valid, op, target_request, pulse_count, now_time, input ready);
  modport sink (input valid, op, target_request, pulse_count, now_time, output ready);
endinterface

interface rvpc_result_if #(
  parameter int COUNT_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    motor_drive;
  logic                          last_direction;
  logic [2:0]                    current_position;
  logic                          count_load;
  logic signed [COUNT_WIDTH-1:0] count_load_value;
  logic                          calibrating;
  logic [2:0]                    target_position;
  logic [1:0]                    request_status;

  modport source (output valid, motor_drive, last_direction, current_position, count_load,
                  count_load_value, calibrating, target_position, request_status,
                  input ready);
  modport sink (input valid, motor_drive, last_direction, current_position, count_load,
                count_load_value, calibrating, target_position, request_status,
                output ready);
endinterface

interface rvpc_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [rvpc_pkg::CFG_INDEX_WIDTH-1:0]   index;
  logic [rvpc_pkg::CFG_DATA_WIDTH-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/rotary_valve_position_controller.sv
`timescale 1ns / 1ps
// a request accepted into the input register passes through the control step into the result register
// throughput: one request per cycle while results are taken, set by the single pass through the control step
// the input register takes a new request while a result waits in the output register
// reset (rst, synchronous, active high): no target, stopped, clockwise, not calibrating,
// stall tracking at count 0 and time 0, configuration back to its default values
// ----------------------------------------------------------------------------
// rotary_valve_position_controller: five-detent rotary valve position control
// finds the nearest detent, seeks the target centre, detects stalls and runs
// the end stop calibration, one result per request
// ----------------------------------------------------------------------------
module rotary_valve_position_controller #(
  parameter int COUNT_WIDTH = 16,
  parameter int TIME_WIDTH  = 32
) (
  input logic            clk,
  input logic            rst,
  rvpc_cmd_if.sink       cmd,
  rvpc_result_if.source  result,
  rvpc_cfg_if.sink       cfg
);

  // --------------------------------------------------------------------------
  // configuration registers, writes always taken
  // --------------------------------------------------------------------------
  rvpc_pkg::cfg_t cfg_q;

  assign cfg.ready = 1'b1;

  rvpc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic                          in_full;
  logic [1:0]                    in_op;
  logic [2:0]                    in_req;
  logic signed [COUNT_WIDTH-1:0] in_count;
  logic [TIME_WIDTH-1:0]         in_time;
  logic                          advance;

  // the held request moves on when the result register is empty or being drained
  assign advance   = in_full && (!result.valid || result.ready);
  assign cmd.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (cmd.ready) begin
      in_full <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_op    <= cmd.op;
      in_req   <= cmd.target_request;
      in_count <= cmd.pulse_count;
      in_time  <= cmd.now_time;
    end
  end

  // --------------------------------------------------------------------------
  // controller state
  // --------------------------------------------------------------------------
  logic [2:0]                    target_detent,    target_detent_next;
  logic [2:0]                    nearest_detent,   nearest_detent_next;
  logic                          calibration_flag, calibration_flag_next;
  logic signed [COUNT_WIDTH-1:0] tracked_count,    tracked_count_next;
  logic [TIME_WIDTH-1:0]         tracked_time,     tracked_time_next;
  rvpc_pkg::drive_t              drive_state,      drive_state_next;
  logic                          direction_flag,   direction_flag_next;

  logic                          load;
  logic signed [COUNT_WIDTH-1:0] load_value;
  rvpc_pkg::status_t             status;

  // --------------------------------------------------------------------------
  // detent finder and stall check
  // --------------------------------------------------------------------------
  rvpc_pkg::detent_info_t info;
  logic                   count_same;
  logic [TIME_WIDTH-1:0]  elapsed;
  logic                   timed_out;

  rvpc_detent #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_detent (
    .count  (in_count),
    .target (target_detent),
    .cfg    (cfg_q),
    .info   (info)
  );

  // elapsed time wraps with the time counter
  assign count_same = (in_count == tracked_count);
  assign elapsed    = in_time - tracked_time;
  assign timed_out  = (elapsed >= TIME_WIDTH'(cfg_q.timeout));

  // --------------------------------------------------------------------------
  // control step
  // --------------------------------------------------------------------------
  always_comb begin
    target_detent_next    = target_detent;
    nearest_detent_next   = nearest_detent;
    calibration_flag_next = calibration_flag;
    tracked_count_next    = tracked_count;
    tracked_time_next     = tracked_time;
    drive_state_next      = drive_state;
    direction_flag_next   = direction_flag;
    load                  = 1'b0;
    load_value            = '0;
    status                = rvpc_pkg::STATUS_NONE;

    unique case (rvpc_pkg::op_t'(in_op))
      rvpc_pkg::OP_TARGET: begin
        // no new target during calibration or beyond the last detent
        if (calibration_flag || (in_req > rvpc_pkg::DETENT_LAST)) begin
          status = rvpc_pkg::STATUS_REJECTED;
        end else begin
          target_detent_next = in_req;
          status             = rvpc_pkg::STATUS_ACCEPTED;
        end
      end
      rvpc_pkg::OP_CALIBRATE: begin
        calibration_flag_next = 1'b1;
        target_detent_next    = rvpc_pkg::DETENT_NONE;
        direction_flag_next   = 1'b0;
        drive_state_next      = rvpc_pkg::DRIVE_CCW;
        tracked_count_next    = in_count;
        tracked_time_next     = in_time;
      end
      rvpc_pkg::OP_TICK: begin
        nearest_detent_next = info.nearest;
        priority if (calibration_flag) begin
          // only stall detection while calibrating
          if (!count_same) begin
            tracked_count_next = in_count;
            tracked_time_next  = in_time;
          end else if (timed_out) begin
            drive_state_next      = rvpc_pkg::DRIVE_STOP;
            load                  = 1'b1;
            calibration_flag_next = 1'b0;
          end
        end else if ((target_detent == rvpc_pkg::DETENT_NONE) || info.in_tolerance) begin
          drive_state_next   = rvpc_pkg::DRIVE_STOP;
          tracked_count_next = in_count;
          tracked_time_next  = in_time;
        end else if (!count_same) begin
          // moving, restart tracking and keep seeking
          tracked_count_next  = in_count;
          tracked_time_next   = in_time;
          direction_flag_next = info.err_positive;
          drive_state_next    = info.err_positive ? rvpc_pkg::DRIVE_CW : rvpc_pkg::DRIVE_CCW;
        end else if (timed_out) begin
          // stalled while seeking, correct the count at the end stops
          drive_state_next   = rvpc_pkg::DRIVE_STOP;
          target_detent_next = rvpc_pkg::DETENT_NONE;
          if (target_detent == rvpc_pkg::DETENT_FIRST) begin
            load = 1'b1;
          end else if (target_detent == rvpc_pkg::DETENT_LAST) begin
            load       = 1'b1;
            load_value = COUNT_WIDTH'(cfg_q.center[rvpc_pkg::NUM_DETENTS-1]);
          end
        end else begin
          direction_flag_next = info.err_positive;
          drive_state_next    = info.err_positive ? rvpc_pkg::DRIVE_CW : rvpc_pkg::DRIVE_CCW;
        end
      end
      rvpc_pkg::OP_UNUSED: ;  // unused code leaves everything as it is
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_detent    <= rvpc_pkg::DETENT_NONE;
      nearest_detent   <= rvpc_pkg::DETENT_NONE;
      calibration_flag <= 1'b0;
      tracked_count    <= '0;
      tracked_time     <= '0;
      drive_state      <= rvpc_pkg::DRIVE_STOP;
      direction_flag   <= 1'b1;
    end else if (advance) begin
      target_detent    <= target_detent_next;
      nearest_detent   <= nearest_detent_next;
      calibration_flag <= calibration_flag_next;
      tracked_count    <= tracked_count_next;
      tracked_time     <= tracked_time_next;
      drive_state      <= drive_state_next;
      direction_flag   <= direction_flag_next;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.motor_drive      <= drive_state_next;
      result.last_direction   <= direction_flag_next;
      result.current_position <= nearest_detent_next;
      result.count_load       <= load;
      result.count_load_value <= load_value;
      result.calibrating      <= calibration_flag_next;
      result.target_position  <= target_detent_next;
      result.request_status   <= status;
    end
  end

`ifndef NO_ASSERTIONS
  // a calibration run never carries a target
  a_calib_no_target: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.calibrating |-> result.target_position == rvpc_pkg::DETENT_NONE)
    else $error("target set during calibration");

  // a count correction always comes with the motor stopped
  a_load_stops: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.count_load |->
      result.motor_drive == rvpc_pkg::DRIVE_STOP && !result.calibrating)
    else $error("count correction while driving");

  // the reported direction agrees with the drive
  a_drive_dir: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.motor_drive != rvpc_pkg::DRIVE_STOP |->
      result.last_direction == (result.motor_drive == rvpc_pkg::DRIVE_CW))
    else $error("drive and direction disagree");

  // a held request that cannot move on stays held
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full)
    else $error("held request lost");
`endif

endmodule

### rtl/rvpc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvpc_cfg_regs: configuration register file
// detent centres, position tolerance and stall timeout
// ----------------------------------------------------------------------------
module rvpc_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [rvpc_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
  input  logic [rvpc_pkg::CFG_DATA_WIDTH-1:0]  wr_data,
  output rvpc_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center[0] <= rvpc_pkg::CENTER1_RESET;
      cfg.center[1] <= rvpc_pkg::CENTER2_RESET;
      cfg.center[2] <= rvpc_pkg::CENTER3_RESET;
      cfg.center[3] <= rvpc_pkg::CENTER4_RESET;
      cfg.center[4] <= rvpc_pkg::CENTER5_RESET;
      cfg.tolerance <= rvpc_pkg::TOLERANCE_RESET;
      cfg.timeout   <= rvpc_pkg::TIMEOUT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        rvpc_pkg::REG_CENTER1:   cfg.center[0] <= wr_data[rvpc_pkg::CENTER_WIDTH-1:0];
        rvpc_pkg::REG_CENTER2:   cfg.center[1] <= wr_data[rvpc_pkg::CENTER_WIDTH-1:0];
        rvpc_pkg::REG_CENTER3:   cfg.center[2] <= wr_data[rvpc_pkg::CENTER_WIDTH-1:0];
        rvpc_pkg::REG_CENTER4:   cfg.center[3] <= wr_data[rvpc_pkg::CENTER_WIDTH-1:0];
        rvpc_pkg::REG_CENTER5:   cfg.center[4] <= wr_data[rvpc_pkg::CENTER_WIDTH-1:0];
        rvpc_pkg::REG_TOLERANCE: cfg.tolerance <= wr_data[rvpc_pkg::TOL_WIDTH-1:0];
        rvpc_pkg::REG_TIMEOUT:   cfg.timeout   <= wr_data[rvpc_pkg::TIMEOUT_WIDTH-1:0];
        default: ;  // writes past the last register are dropped
      endcase
    end
  end

endmodule

### rtl/rvpc_detent.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvpc_detent: nearest detent and error to the target centre
// ties between two centres go to the lower detent
// ----------------------------------------------------------------------------
module rvpc_detent #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic signed [COUNT_WIDTH-1:0] count,
  input  logic [2:0]                    target,
  input  rvpc_pkg::cfg_t                cfg,
  output rvpc_pkg::detent_info_t        info
);

  // one bit above the wider of count and the centre with a sign bit added
  localparam int DW = ((COUNT_WIDTH > rvpc_pkg::CENTER_WIDTH) ?
                       COUNT_WIDTH : rvpc_pkg::CENTER_WIDTH + 1) + 1;

  logic signed [DW-1:0] count_ext;
  logic signed [DW-1:0] diff [rvpc_pkg::NUM_DETENTS];
  logic [DW-1:0]        gap [rvpc_pkg::NUM_DETENTS];
  logic [DW-1:0]        best;
  logic [2:0]           pos;
  logic [rvpc_pkg::CENTER_WIDTH-1:0] target_center;
  logic signed [DW-1:0] err;
  logic [DW-1:0]        err_mag;

  assign count_ext = DW'(count);

  always_comb begin
    for (int k = 0; k < rvpc_pkg::NUM_DETENTS; k++) begin
      diff[k] = count_ext - $signed(DW'(cfg.center[k]));
      gap[k]  = diff[k][DW-1] ? DW'(-diff[k]) : DW'(diff[k]);
    end
  end

  // compare chain, strictly smaller wins so the lower detent keeps ties
  always_comb begin
    best = gap[0];
    pos  = rvpc_pkg::DETENT_FIRST;
    for (int k = 1; k < rvpc_pkg::NUM_DETENTS; k++) begin
      if (gap[k] < best) begin
        best = gap[k];
        pos  = 3'(k + 1);
      end
    end
  end

  always_comb begin
    unique case (target)
      rvpc_pkg::DETENT_FIRST: target_center = cfg.center[0];
      rvpc_pkg::DETENT_2:     target_center = cfg.center[1];
      rvpc_pkg::DETENT_3:     target_center = cfg.center[2];
      rvpc_pkg::DETENT_4:     target_center = cfg.center[3];
      rvpc_pkg::DETENT_LAST:  target_center = cfg.center[4];
      default:                target_center = cfg.center[0];
    endcase
  end

  assign err     = $signed(DW'(target_center)) - count_ext;
  assign err_mag = err[DW-1] ? DW'(-err) : DW'(err);

  assign info.nearest      = pos;
  assign info.in_tolerance = (err_mag <= DW'(cfg.tolerance));
  assign info.err_positive = !err[DW-1] && (err != '0);

endmodule

### tb/valve_check_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// valve_check_pkg: expected behaviour of the rotary valve position controller
// keeps its own copy of the control state and settings, predicts one result
// per accepted request and compares results field by field in order
// ----------------------------------------------------------------------------
package valve_check_pkg;

  import rvpc_pkg::*;

  localparam int MAX_PRINTED = 60;

  typedef struct packed {
    drive_t             motor_drive;
    logic               last_direction;
    logic [2:0]         current_position;
    logic               count_load;
    logic signed [15:0] count_load_value;
    logic               calibrating;
    logic [2:0]         target_position;
    status_t            request_status;
  } valve_result_t;

  class valve_position_scoreboard;

    bit [CENTER_WIDTH-1:0]  center [NUM_DETENTS];
    bit [TOL_WIDTH-1:0]     tolerance;
    bit [TIMEOUT_WIDTH-1:0] timeout;

    bit [2:0]  target;
    bit [2:0]  nearest;
    bit        calibrating;
    bit [15:0] tracked_count;
    bit [31:0] tracked_time;
    drive_t    drive;
    bit        direction_cw;

    valve_result_t expected_results [$];
    int unsigned   mismatch_count;

    function new();
      center      = '{CENTER1_RESET, CENTER2_RESET, CENTER3_RESET, CENTER4_RESET,
                      CENTER5_RESET};
      tolerance   = TOLERANCE_RESET;
      timeout     = TIMEOUT_RESET;
      target      = DETENT_NONE;
      nearest     = DETENT_NONE;
      calibrating = 1'b0;
      tracked_count = '0;
      tracked_time  = '0;
      drive        = DRIVE_STOP;
      direction_cw = 1'b1;
      mismatch_count = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void write_register(logic [CFG_INDEX_WIDTH-1:0] index,
                                 logic [CFG_DATA_WIDTH-1:0] data);
      case (index)
        REG_CENTER1, REG_CENTER2, REG_CENTER3, REG_CENTER4, REG_CENTER5:
          center[index] = data[CENTER_WIDTH-1:0];
        REG_TOLERANCE: tolerance = data[TOL_WIDTH-1:0];
        REG_TIMEOUT:   timeout = data[TIMEOUT_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // unchanged count for at least the timeout, elapsed time taken modulo 2^32
    function bit count_stalled(bit [15:0] count, bit [31:0] now);
      if (count != tracked_count) begin
        tracked_count = count;
        tracked_time  = now;
        return 1'b0;
      end
      return (now - tracked_time) >= 32'(timeout);
    endfunction

    function void note_request(op_t op, bit [2:0] req, bit [15:0] count, bit [31:0] now);
      valve_result_t predicted;
      int            c;
      int            best;
      int            gap;
      int            err;
      int            k;
      bit            load;
      bit [15:0]     load_value;
      status_t       status;
      c          = $signed(count);
      load       = 1'b0;
      load_value = '0;
      status     = STATUS_NONE;
      case (op)
        OP_TARGET: begin
          if (calibrating || req > DETENT_LAST) begin
            status = STATUS_REJECTED;
          end else begin
            target = req;
            status = STATUS_ACCEPTED;
          end
        end
        OP_CALIBRATE: begin
          calibrating   = 1'b1;
          target        = DETENT_NONE;
          direction_cw  = 1'b0;
          drive         = DRIVE_CCW;
          tracked_count = count;
          tracked_time  = now;
        end
        OP_TICK: begin
          // nearest centre, ties to the lower detent
          best    = c - int'(center[0]);
          best    = best < 0 ? -best : best;
          nearest = DETENT_FIRST;
          for (k = 1; k < NUM_DETENTS; k++) begin
            gap = c - int'(center[k]);
            gap = gap < 0 ? -gap : gap;
            if (gap < best) begin
              best    = gap;
              nearest = 3'(k + 1);
            end
          end
          if (calibrating) begin
            if (count_stalled(count, now)) begin
              drive       = DRIVE_STOP;
              load        = 1'b1;
              calibrating = 1'b0;
            end
          end else if (target == DETENT_NONE) begin
            drive         = DRIVE_STOP;
            tracked_count = count;
            tracked_time  = now;
          end else begin
            err = int'(center[target - 1]) - c;
            if ((err < 0 ? -err : err) > int'(tolerance)) begin
              if (count_stalled(count, now)) begin
                drive = DRIVE_STOP;
                if (target == DETENT_FIRST) begin
                  load = 1'b1;
                end else if (target == DETENT_LAST) begin
                  load       = 1'b1;
                  load_value = {1'b0, center[NUM_DETENTS-1]};
                end
                target = DETENT_NONE;
              end else if (err > 0) begin
                direction_cw = 1'b1;
                drive        = DRIVE_CW;
              end else begin
                direction_cw = 1'b0;
                drive        = DRIVE_CCW;
              end
            end else begin
              drive         = DRIVE_STOP;
              tracked_count = count;
              tracked_time  = now;
            end
          end
        end
        default: ;
      endcase
      predicted.motor_drive      = drive;
      predicted.last_direction   = direction_cw;
      predicted.current_position = nearest;
      predicted.count_load       = load;
      predicted.count_load_value = load_value;
      predicted.calibrating      = calibrating;
      predicted.target_position  = target;
      predicted.request_status   = status;
      expected_results.push_back(predicted);
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_result(valve_result_t seen);
      valve_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no request waiting");
        return;
      end
      want = expected_results.pop_front();
      if (seen.motor_drive !== want.motor_drive)
        report_mismatch($sformatf("motor_drive %0d, expected %0d",
                                  seen.motor_drive, want.motor_drive));
      if (seen.last_direction !== want.last_direction)
        report_mismatch($sformatf("last_direction %0d, expected %0d",
                                  seen.last_direction, want.last_direction));
      if (seen.current_position !== want.current_position)
        report_mismatch($sformatf("current_position %0d, expected %0d",
                                  seen.current_position, want.current_position));
      if (seen.count_load !== want.count_load)
        report_mismatch($sformatf("count_load %0d, expected %0d",
                                  seen.count_load, want.count_load));
      if (seen.count_load_value !== want.count_load_value)
        report_mismatch($sformatf("count_load_value %0d, expected %0d",
                                  seen.count_load_value, want.count_load_value));
      if (seen.calibrating !== want.calibrating)
        report_mismatch($sformatf("calibrating %0d, expected %0d",
                                  seen.calibrating, want.calibrating));
      if (seen.target_position !== want.target_position)
        report_mismatch($sformatf("target_position %0d, expected %0d",
                                  seen.target_position, want.target_position));
      if (seen.request_status !== want.request_status)
        report_mismatch($sformatf("request_status %0d, expected %0d",
                                  seen.request_status, want.request_status));
    endtask

  endclass

endpackage

### tb/tb_rotary_valve_position_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotary_valve_position_controller: self-checking bench of the valve controller
// directed end stop, tie, stall and calibration cases, then seek and calibration runs,
// detent probes and noise with random content under several settings, with random idling on both sides
// ----------------------------------------------------------------------------
module tb_rotary_valve_position_controller;

  import rvpc_pkg::*;
  import valve_check_pkg::*;

  localparam int HOLD_CYCLES = 60;

  logic clk = 1'b0;
  logic rst;

  rvpc_cmd_if #(.COUNT_WIDTH(16), .TIME_WIDTH(32)) cmd_bus ();
  rvpc_result_if #(.COUNT_WIDTH(16)) result_bus ();
  rvpc_cfg_if cfg_bus ();

  valve_position_scoreboard sb = new();

  // free running time seen by the block, wraps like the real counter
  logic [31:0] valve_now = '0;
  int unsigned requests_sent = 0;
  int unsigned sender_idle_pct = 6;
  int unsigned receiver_idle_pct = 82;
  bit          hold_pending = 1'b0;
  int unsigned hold_left = 0;

  rotary_valve_position_controller #(
    .COUNT_WIDTH (16),
    .TIME_WIDTH  (32)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver side: random back-pressure, plus one long hold-off when asked for
  initial begin
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_left    = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // every accepted result goes to the scoreboard
  always @(posedge clk) begin : result_monitor
    valve_result_t seen;
    if (rst === 1'b0 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      seen.motor_drive      = drive_t'(result_bus.motor_drive);
      seen.last_direction   = result_bus.last_direction;
      seen.current_position = result_bus.current_position;
      seen.count_load       = result_bus.count_load;
      seen.count_load_value = result_bus.count_load_value;
      seen.calibrating      = result_bus.calibrating;
      seen.target_position  = result_bus.target_position;
      seen.request_status   = status_t'(result_bus.request_status);
      sb.check_result(seen);
    end
  end

  function automatic logic signed [15:0] clamp_count(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic logic signed [15:0] near_center(int k, int spread);
    return clamp_count(int'(sb.center[k]) + int'($urandom_range(2 * spread)) - spread);
  endfunction

  // one request on the command channel; returns at the edge that takes it
  task automatic send_request(input op_t op, input logic [2:0] req,
                              input logic signed [15:0] count, input logic [31:0] now);
    // idling pattern follows progress: sender rarely idle, then receiver, then neither
    if (requests_sent < 350) begin
      sender_idle_pct   = 6;
      receiver_idle_pct = 82;
    end else if (requests_sent < 700) begin
      sender_idle_pct   = 82;
      receiver_idle_pct = 6;
    end else begin
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
    end
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_bus.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_bus.valid          <= 1'b1;
    cmd_bus.op             <= op;
    cmd_bus.target_request <= req;
    cmd_bus.pulse_count    <= count;
    cmd_bus.now_time       <= now;
    do @(posedge clk); while (cmd_bus.ready !== 1'b1);
    sb.note_request(op, req, count, now);
    if (op != OP_UNUSED) requests_sent++;
  endtask

  task automatic tick_at(input logic signed [15:0] count, input int unsigned dt);
    valve_now = valve_now + dt;
    send_request(OP_TICK, 3'($urandom), count, valve_now);
  endtask

  task automatic ask(input logic [2:0] goal);
    send_request(OP_TARGET, goal, 16'($urandom), valve_now);
  endtask

  // hold the count still until the stall timeout has surely run out
  task automatic stall_at(input logic signed [15:0] count);
    int unsigned waited;
    int unsigned dt;
    tick_at(count, 1);
    waited = 0;
    while (waited <= sb.timeout) begin
      dt = $urandom_range(sb.timeout / 2 + 1);
      waited += dt;
      tick_at(count, dt);
    end
  endtask

  task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                                input logic [CFG_DATA_WIDTH-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= index;
    cfg_bus.data  <= data;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    sb.write_register(index, data);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // settings change only once every result is home and the pipeline is empty
  task automatic drain_results();
    @(negedge clk);
    cmd_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // dirty sets the bits above each register's width, which must be dropped
  task automatic apply_settings(input int c1, input int c2, input int c3, input int c4,
                                input int c5, input int tol, input int tmo, input bit dirty);
    write_register(REG_CENTER1, {dirty ? 1'($urandom) : 1'b0, 15'(c1)});
    write_register(REG_CENTER2, {dirty ? 1'($urandom) : 1'b0, 15'(c2)});
    write_register(REG_CENTER3, {dirty ? 1'($urandom) : 1'b0, 15'(c3)});
    write_register(REG_CENTER4, {dirty ? 1'($urandom) : 1'b0, 15'(c4)});
    write_register(REG_CENTER5, {dirty ? 1'($urandom) : 1'b0, 15'(c5)});
    write_register(REG_TOLERANCE, {dirty ? 6'($urandom) : 6'd0, 10'(tol)});
    write_register(REG_TIMEOUT, 16'(tmo));
  endtask

  // target request followed by ticks moving towards the centre, maybe overshooting,
  // sometimes left stuck until it stalls
  task automatic seek_run();
    logic [2:0] goal;
    int         pos;
    int         aim;
    int         gap;
    int         span;
    int         step;
    goal = 3'($urandom_range(5, 1));
    if ($urandom_range(9) == 0) goal = 3'($urandom_range(7));
    pos = int'($urandom_range(65535)) - 32768;
    if ($urandom_range(1) != 0) pos = near_center($urandom_range(4), 2000);
    ask(goal);
    aim = pos;
    if (goal >= DETENT_FIRST && goal <= DETENT_LAST) aim = int'(sb.center[goal - 1]);
    repeat ($urandom_range(12, 2)) begin
      if ($urandom_range(3) != 0) begin
        gap  = aim - pos;
        span = (gap < 0 ? -gap : gap) / 2 + int'(sb.tolerance) + 2;
        step = int'($urandom_range(span));
        pos  = int'(clamp_count(gap < 0 ? pos - step : pos + step));
      end
      tick_at(clamp_count(pos), $urandom_range(sb.timeout / 3 + 1));
    end
    if ($urandom_range(1) != 0) stall_at(clamp_count(pos));
  endtask

  // calibration: counterclockwise travel, stray requests, then the end stop
  task automatic calibration_run();
    int pos;
    pos = int'($urandom_range(65535)) - 32768;
    send_request(OP_CALIBRATE, 3'($urandom), clamp_count(pos), valve_now);
    repeat ($urandom_range(6)) begin
      case ($urandom_range(5))
        0: ask(3'($urandom));
        1: tick_at(clamp_count(pos), $urandom_range(sb.timeout / 3 + 1));
        default: begin
          pos = int'(clamp_count(pos - int'($urandom_range(300))));
          tick_at(clamp_count(pos), $urandom_range(sb.timeout / 3 + 1));
        end
      endcase
    end
    if ($urandom_range(3) != 0) stall_at(clamp_count(pos));
  endtask

  // counts around a centre or halfway between two, for the nearest detent search
  task automatic detent_probe();
    int k;
    int pos;
    k = $urandom_range(NUM_DETENTS - 1);
    if ($urandom_range(3) == 0 && k < NUM_DETENTS - 1)
      pos = (int'(sb.center[k]) + int'(sb.center[k + 1])) / 2;
    else
      pos = int'(near_center(k, int'(sb.tolerance) + 3));
    if ($urandom_range(2) == 0) ask(3'($urandom_range(5)));
    tick_at(clamp_count(pos), $urandom_range(sb.timeout / 3 + 1));
  endtask

  task automatic random_phase(input int unsigned goal_count);
    int unsigned pick;
    while (requests_sent < goal_count) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        seek_run();
      end else if (pick < 60) begin
        calibration_run();
      end else if (pick < 85) begin
        detent_probe();
      end else begin
        // noise: any op, any field, and a jump of the time counter
        valve_now = $urandom;
        send_request(op_t'($urandom_range(3)), 3'($urandom), 16'($urandom), valve_now);
      end
    end
  endtask

  initial begin
    rst                    = 1'b1;
    cmd_bus.valid          = 1'b0;
    cmd_bus.op             = OP_TICK;
    cmd_bus.target_request = DETENT_NONE;
    cmd_bus.pulse_count    = '0;
    cmd_bus.now_time       = '0;
    cfg_bus.valid          = 1'b0;
    cfg_bus.index          = REG_CENTER1;
    cfg_bus.data           = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, default settings
    tick_at(16'sd0, 0);                       // first tick, no target yet
    send_request(OP_UNUSED, DETENT_LAST, 16'sh7FFF, 32'hFFFF_FFFF);
    ask(3'd7);                                // beyond the last detent
    ask(3'd6);
    ask(DETENT_NONE);
    ask(DETENT_3);
    tick_at(16'sh8000, 1);                    // far below, drive clockwise
    tick_at(16'sh7FFF, 1);                    // far above, drive counterclockwise
    tick_at(16'sh7FFF, 100);                  // stall on a middle detent, no load
    tick_at(16'sd120, 3);                     // halfway between one and two
    ask(DETENT_FIRST);
    tick_at(16'sd500, 1);
    tick_at(16'sd500, 100);                   // stall seeking detent one, load zero
    ask(DETENT_LAST);
    tick_at(16'sd100, 1);
    tick_at(16'sd100, 100);                   // stall seeking detent five, load its centre
    ask(DETENT_2);
    tick_at(16'sd245, 5);                     // within tolerance
    tick_at(16'sd251, 5);                     // just outside it
    send_request(OP_CALIBRATE, 3'($urandom), -16'sd5, valve_now);
    ask(DETENT_2);                            // refused while calibrating
    tick_at(-16'sd7, 10);
    tick_at(-16'sd7, 50);
    send_request(OP_CALIBRATE, 3'($urandom), -16'sd7, valve_now);   // restart mid run
    tick_at(-16'sd7, 99);
    tick_at(-16'sd7, 1);                      // end stop reached, count zeroed
    valve_now = 32'hFFFF_FFC0;
    ask(DETENT_4);
    tick_at(16'sd0, 0);
    tick_at(16'sd0, 100);                     // stall measured across the time wrap

    // defaults, with one long hold-off at the receiver
    hold_pending = 1'b1;
    random_phase(290);

    // extreme centres, widest tolerance, longest timeout
    drain_results();
    apply_settings(0, 8000, 16000, 24000, 32767, 1023, 65535, 1'b0);
    random_phase(550);

    // scattered centres with a tie, zero tolerance, zero timeout
    drain_results();
    begin : scattered_settings
      int c2;
      c2 = $urandom_range(32767);
      apply_settings($urandom_range(32767), c2, c2, $urandom_range(32767),
                     $urandom_range(32767), 0, 0, 1'b1);
    end
    random_phase(810);

    // centres in falling order, timeout of one, second hold-off with no idling
    drain_results();
    apply_settings(32767, 30000, 200, 200, 5, $urandom_range(50), 1, 1'b0);
    hold_pending = 1'b1;
    random_phase(1060);

    drain_results();
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
